// ===== design/ccs_pkg.sv =====
package ccs_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned MAX_OUT = 4;                 // output bytes per input beat
    localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);
    localparam int unsigned IDX_W   = $clog2(MAX_OUT);
    localparam int unsigned MAX_PUSH = 3;                // lexer steps per input beat

    typedef logic [BYTE_W-1:0] byte_t;

    localparam byte_t CH_BSLASH = 8'h5C;
    localparam byte_t CH_LF     = 8'h0A;
    localparam byte_t CH_CR     = 8'h0D;
    localparam byte_t CH_STAR   = 8'h2A;
    localparam byte_t CH_SLASH  = 8'h2F;
    localparam byte_t CH_DQUOTE = 8'h22;
    localparam byte_t CH_SQUOTE = 8'h27;
    localparam byte_t CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        SP_IDLE,
        SP_BSL,
        SP_BSL_CR
    } splice_t;

    typedef enum logic [2:0] {
        LX_CODE,
        LX_LINE,
        LX_BLOCK,
        LX_BLOCK_STAR,
        LX_STRING,
        LX_CHAR
    } lex_mode_t;

    typedef struct packed {
        lex_mode_t mode;
        logic      held;     // slash held in code, waiting for the next byte
        logic      esc;      // previous literal byte was an escaping backslash
    } lex_st_t;

    typedef struct packed {
        lex_st_t    st;
        logic [1:0] n;       // bytes produced, 0 to 2
        byte_t      b0;
        byte_t      b1;
    } lex_out_t;

    localparam lex_st_t LEX_RESET = '{mode: LX_CODE, held: 1'b0, esc: 1'b0};

    // One lexer step on one spliced byte.
    function automatic lex_out_t lex_step(lex_st_t st, byte_t c);
        lex_out_t r;
        r    = '0;
        r.st = st;
        unique case (st.mode)
            LX_LINE:
            begin
                r.n = 2'd1;
                if (c == CH_LF)
                begin
                    r.b0      = CH_LF;
                    r.st.mode = LX_CODE;
                end
                else
                begin
                    r.b0 = CH_SPACE;
                end
            end
            LX_BLOCK, LX_BLOCK_STAR:
            begin
                r.n = 2'd1;
                if (st.mode == LX_BLOCK_STAR && c == CH_SLASH)
                begin
                    r.b0      = CH_SPACE;
                    r.st.mode = LX_CODE;
                end
                else if (c == CH_STAR)
                begin
                    r.b0      = CH_SPACE;
                    r.st.mode = LX_BLOCK_STAR;
                end
                else
                begin
                    r.b0      = (c == CH_LF) ? CH_LF : CH_SPACE;
                    r.st.mode = LX_BLOCK;
                end
            end
            LX_STRING, LX_CHAR:
            begin
                r.n  = 2'd1;
                r.b0 = c;
                if (st.esc)
                begin
                    r.st.esc = 1'b0;
                end
                else if (c == CH_BSLASH)
                begin
                    r.st.esc = 1'b1;
                end
                else if ((st.mode == LX_STRING && c == CH_DQUOTE) ||
                         (st.mode == LX_CHAR && c == CH_SQUOTE))
                begin
                    r.st.mode = LX_CODE;
                end
            end
            default:
            begin
                r.st.mode = LX_CODE;
                if (st.held && (c == CH_SLASH || c == CH_STAR))
                begin
                    // comment opener: both bytes become spaces
                    r.st.held = 1'b0;
                    r.n       = 2'd2;
                    r.b0      = CH_SPACE;
                    r.b1      = CH_SPACE;
                    r.st.mode = (c == CH_SLASH) ? LX_LINE : LX_BLOCK;
                end
                else if (st.held)
                begin
                    r.b0 = CH_SLASH;
                    if (c == CH_SLASH)
                    begin
                        r.n       = 2'd1;
                        r.st.held = 1'b1;
                    end
                    else
                    begin
                        r.n       = 2'd2;
                        r.b1      = c;
                        r.st.held = 1'b0;
                        if (c == CH_DQUOTE)
                            r.st.mode = LX_STRING;
                        else if (c == CH_SQUOTE)
                            r.st.mode = LX_CHAR;
                    end
                end
                else if (c == CH_SLASH)
                begin
                    r.n       = 2'd0;
                    r.st.held = 1'b1;
                end
                else
                begin
                    r.n  = 2'd1;
                    r.b0 = c;
                    if (c == CH_DQUOTE)
                        r.st.mode = LX_STRING;
                    else if (c == CH_SQUOTE)
                        r.st.mode = LX_CHAR;
                end
            end
        endcase
        return r;
    endfunction

endpackage

// ===== design/c_comment_stripper.sv =====
// An accepted beat waits in the input register and moves into the result register once that
//   register is free; its output bytes are then offered from the result register.
// Throughput: one input beat a cycle while each beat gives at most one output beat and the
//   output is not stalled; a beat that gives more output beats (up to four) holds the input
//   side while the single output register drains them, one byte a cycle while m_tready is high.
// Reset (rst_n low, asynchronous): both registers empty, splicer idle, lexer in code state.
module c_comment_stripper
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave side
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [7:0] in_byte
    input  logic                 s_tlast,    // in_last
    // master side
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,    // [7:0] out_byte
    output logic                 m_tlast     // out_last
);
    import ccs_pkg::*;

    // input register
    logic    in_valid_reg, in_valid_next;
    byte_t   in_byte_reg;
    logic    in_last_reg;

    // text state, advanced when a beat moves into the result register
    splice_t splice_reg, splice_next;
    lex_st_t lex_reg, lex_next;

    // result register: up to MAX_OUT bytes, drained one a beat
    byte_t             res_byte_reg [MAX_OUT];
    byte_t             res_byte_next [MAX_OUT];
    logic [CNT_W-1:0]  res_rem_reg, res_rem_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic              res_last_reg, res_last_next;

    logic              buf_free;
    logic              in_move;
    logic              out_take;
    logic [CNT_W-1:0]  gen_cnt;

    assign out_take = m_tvalid && m_tready;
    // result register empty, or handing over its final byte this cycle
    assign buf_free = (res_rem_reg == '0) ||
                      (res_rem_reg == CNT_W'(1) && m_tready);
    assign in_move  = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || buf_free;

    assign m_tvalid = (res_rem_reg != '0);
    assign m_tdata  = res_byte_reg[res_idx_reg];
    assign m_tlast  = res_last_reg && (res_rem_reg == CNT_W'(1));

    // splice, then up to three lexer steps, then end-of-text flush
    always_comb
    begin
        byte_t    pch [MAX_PUSH];
        logic     pv  [MAX_PUSH];
        lex_st_t  lx;
        lex_out_t r;
        byte_t    c;

        c = in_byte_reg;
        r = '0;
        for (int i = 0; i < MAX_PUSH; i++)
        begin
            pch[i] = CH_SPACE;
            pv[i]  = 1'b0;
        end
        splice_next = SP_IDLE;

        unique case (splice_reg)
            SP_BSL:
            begin
                if (c == CH_LF)
                begin
                    pch[0] = CH_SPACE;  pv[0] = 1'b1;
                end
                else if (c == CH_CR)
                begin
                    splice_next = SP_BSL_CR;
                end
                else if (c == CH_BSLASH)
                begin
                    pch[0] = CH_BSLASH; pv[0] = 1'b1;
                    splice_next = SP_BSL;
                end
                else
                begin
                    pch[0] = CH_BSLASH; pv[0] = 1'b1;
                    pch[1] = c;         pv[1] = 1'b1;
                end
            end
            SP_BSL_CR:
            begin
                if (c == CH_LF)
                begin
                    pch[0] = CH_SPACE;  pv[0] = 1'b1;
                end
                else
                begin
                    // backslash CR without LF: both pass, byte handled afresh
                    pch[0] = CH_BSLASH; pv[0] = 1'b1;
                    pch[1] = CH_CR;     pv[1] = 1'b1;
                    if (c == CH_BSLASH)
                        splice_next = SP_BSL;
                    else
                    begin
                        pch[2] = c;     pv[2] = 1'b1;
                    end
                end
            end
            default:
            begin
                if (c == CH_BSLASH)
                    splice_next = SP_BSL;
                else
                begin
                    pch[0] = c;         pv[0] = 1'b1;
                end
            end
        endcase

        // last byte: held splice bytes go to the lexer
        if (in_last_reg)
        begin
            if (splice_next == SP_BSL)
            begin
                pch[MAX_PUSH-1] = CH_BSLASH; pv[MAX_PUSH-1] = 1'b1;
            end
            else if (splice_next == SP_BSL_CR)
            begin
                pch[MAX_PUSH-2] = CH_BSLASH; pv[MAX_PUSH-2] = 1'b1;
                pch[MAX_PUSH-1] = CH_CR;     pv[MAX_PUSH-1] = 1'b1;
            end
            splice_next = SP_IDLE;
        end

        lx      = lex_reg;
        gen_cnt = '0;
        for (int i = 0; i < MAX_OUT; i++)
            res_byte_next[i] = CH_SPACE;

        for (int i = 0; i < MAX_PUSH; i++)
        begin
            if (pv[i])
            begin
                r  = lex_step(lx, pch[i]);
                lx = r.st;
                if (r.n != 2'd0 && gen_cnt < CNT_W'(MAX_OUT))
                begin
                    res_byte_next[gen_cnt[IDX_W-1:0]] = r.b0;
                    gen_cnt = gen_cnt + CNT_W'(1);
                end
                if (r.n == 2'd2 && gen_cnt < CNT_W'(MAX_OUT))
                begin
                    res_byte_next[gen_cnt[IDX_W-1:0]] = r.b1;
                    gen_cnt = gen_cnt + CNT_W'(1);
                end
            end
        end

        lex_next = lx;
        if (in_last_reg)
        begin
            // a held slash at end of text is a plain slash
            if (lx.held && gen_cnt < CNT_W'(MAX_OUT) &&
                (lx.mode == LX_CODE || lx.mode > LX_CHAR))
            begin
                res_byte_next[gen_cnt[IDX_W-1:0]] = CH_SLASH;
                gen_cnt = gen_cnt + CNT_W'(1);
            end
            lex_next = LEX_RESET;
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (in_move)
            in_valid_next = 1'b0;

        res_rem_next  = res_rem_reg;
        res_idx_next  = res_idx_reg;
        res_last_next = res_last_reg;
        if (in_move)
        begin
            res_rem_next  = gen_cnt;
            res_idx_next  = '0;
            res_last_next = in_last_reg;
        end
        else if (out_take)
        begin
            res_rem_next = res_rem_reg - CNT_W'(1);
            res_idx_next = res_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            splice_reg   <= SP_IDLE;
            lex_reg      <= LEX_RESET;
            res_rem_reg  <= '0;
            res_idx_reg  <= '0;
            res_last_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            res_rem_reg  <= res_rem_next;
            res_idx_reg  <= res_idx_next;
            res_last_reg <= res_last_next;
            if (in_move)
            begin
                splice_reg <= splice_next;
                lex_reg    <= lex_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (in_move)
        begin
            for (int i = 0; i < MAX_OUT; i++)
                res_byte_reg[i] <= res_byte_next[i];
        end
    end

endmodule

// ===== design/ccs_checker.sv =====
module ccs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // stalled input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("input beat changed while stalled");

    // nothing pending on the output: the input side must be open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // input stays closed while the output side stays stalled
    a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && !m_tready |=> !s_tready || m_tready)
        else $error("input reopened without output progress");

    // no output during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccs_pkg::*;

    // One stimulus beat. 'typed' rows carry a hand-written single-byte result
    // in 'eb'; all other beats are checked against the predictor below.
    typedef struct packed {
        byte_t b;
        logic  last;
        logic  typed;
        byte_t eb;
    } stim_t;

    // One cleaned byte as it should appear on the master side.
    typedef struct packed {
        byte_t b;
        logic  last;
    } clean_t;

    localparam int N_DIRECTED = 26;
    localparam int N_RANDOM   = 445;

    // Directed opening. Groups: lone extremes; line comment with a CR LF
    // splice inside it; block comment closed by star-slash; string holding
    // an escaped NUL; char literal with backslash-CR not followed by LF;
    // block comment left open at the end of the text.
    localparam stim_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h00,     1'b1, 1'b1, 8'h00},       // NUL alone passes, flagged last
        '{8'hFF,     1'b1, 1'b1, 8'hFF},
        '{CH_SLASH,  1'b1, 1'b1, CH_SLASH},    // held slash released at end
        '{CH_BSLASH, 1'b1, 1'b1, CH_BSLASH},   // held backslash released at end
        '{CH_SLASH,  1'b0, 1'b0, 8'h00},
        '{CH_SLASH,  1'b0, 1'b0, 8'h00},
        '{CH_BSLASH, 1'b0, 1'b0, 8'h00},
        '{CH_CR,     1'b0, 1'b0, 8'h00},
        '{CH_LF,     1'b0, 1'b0, 8'h00},       // splice: space, comment goes on
        '{CH_LF,     1'b0, 1'b0, 8'h00},       // ends the line comment
        '{CH_SLASH,  1'b0, 1'b0, 8'h00},
        '{CH_STAR,   1'b0, 1'b0, 8'h00},
        '{CH_STAR,   1'b0, 1'b0, 8'h00},
        '{CH_SLASH,  1'b0, 1'b0, 8'h00},
        '{CH_DQUOTE, 1'b0, 1'b0, 8'h00},
        '{CH_BSLASH, 1'b0, 1'b0, 8'h00},
        '{8'h00,     1'b0, 1'b0, 8'h00},       // escaped NUL
        '{CH_DQUOTE, 1'b0, 1'b0, 8'h00},
        '{CH_SQUOTE, 1'b0, 1'b0, 8'h00},
        '{CH_BSLASH, 1'b0, 1'b0, 8'h00},
        '{CH_CR,     1'b0, 1'b0, 8'h00},
        '{8'h71,     1'b0, 1'b0, 8'h00},       // no LF: backslash, CR and 'q' pass
        '{CH_SQUOTE, 1'b0, 1'b0, 8'h00},
        '{CH_SLASH,  1'b0, 1'b0, 8'h00},
        '{CH_STAR,   1'b0, 1'b0, 8'h00},
        '{CH_LF,     1'b1, 1'b0, 8'h00}        // open block comment at end
    };

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    c_comment_stripper dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Beats offered to the block, oldest first; popped on acceptance.
    stim_t  offered_q [$];
    // Cleaned bytes still owed by the block.
    clean_t clean_q [$];
    // Raw text under construction for the random part.
    byte_t  text_buf [$];

    int fail_count = 0;
    int burst_left = 0;

    // Shadow state of the stripper
    splice_t   join_st;
    lex_mode_t scan_mode;
    logic      slash_waiting;
    byte_t     pending_byte;
    logic      lit_escape;

    // Bytes produced by the beat being predicted (capped like the block)
    byte_t out_buf [MAX_OUT];
    int    out_n;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_stripper();
        join_st       = SP_IDLE;
        scan_mode     = LX_CODE;
        slash_waiting = 1'b0;
        pending_byte  = '0;
        lit_escape    = 1'b0;
    endfunction

    function automatic void put_clean(byte_t b);
        if (out_n < MAX_OUT)
        begin
            out_buf[out_n] = b;
            out_n++;
        end
    endfunction

    // Second stage: comment and literal tracking on one spliced byte.
    function automatic void scan_byte(byte_t c);
        case (scan_mode)
            LX_LINE:
            begin
                if (c == CH_LF)
                begin
                    put_clean(CH_LF);
                    scan_mode = LX_CODE;
                end
                else
                    put_clean(CH_SPACE);
            end
            LX_BLOCK, LX_BLOCK_STAR:
            begin
                if (scan_mode == LX_BLOCK_STAR && c == CH_SLASH)
                begin
                    put_clean(CH_SPACE);
                    scan_mode = LX_CODE;
                end
                else if (c == CH_STAR)
                begin
                    put_clean(CH_SPACE);
                    scan_mode = LX_BLOCK_STAR;
                end
                else
                begin
                    put_clean((c == CH_LF) ? CH_LF : CH_SPACE);
                    scan_mode = LX_BLOCK;
                end
            end
            LX_STRING, LX_CHAR:
            begin
                put_clean(c);
                if (lit_escape)
                    lit_escape = 1'b0;
                else if (c == CH_BSLASH)
                    lit_escape = 1'b1;
                else if ((scan_mode == LX_STRING && c == CH_DQUOTE) ||
                         (scan_mode == LX_CHAR && c == CH_SQUOTE))
                    scan_mode = LX_CODE;
            end
            default:
            begin
                scan_mode = LX_CODE;
                if (slash_waiting)
                begin
                    slash_waiting = 1'b0;
                    if (c == CH_SLASH || c == CH_STAR)
                    begin
                        // comment opener: both bytes blanked
                        put_clean(CH_SPACE);
                        put_clean(CH_SPACE);
                        scan_mode = (c == CH_SLASH) ? LX_LINE : LX_BLOCK;
                        return;
                    end
                    put_clean(pending_byte);
                end
                if (c == CH_SLASH)
                begin
                    pending_byte  = c;
                    slash_waiting = 1'b1;
                end
                else
                begin
                    put_clean(c);
                    if (c == CH_DQUOTE)
                        scan_mode = LX_STRING;
                    else if (c == CH_SQUOTE)
                        scan_mode = LX_CHAR;
                end
            end
        endcase
    endfunction

    function automatic void join_fresh(byte_t c);
        if (c == CH_BSLASH)
            join_st = SP_BSL;
        else
        begin
            join_st = SP_IDLE;
            scan_byte(c);
        end
    endfunction

    // First stage: backslash-newline splicing.
    function automatic void join_byte(byte_t c);
        case (join_st)
            SP_BSL:
            begin
                if (c == CH_LF)
                begin
                    scan_byte(CH_SPACE);
                    join_st = SP_IDLE;
                end
                else if (c == CH_CR)
                    join_st = SP_BSL_CR;
                else if (c == CH_BSLASH)
                    scan_byte(CH_BSLASH);
                else
                begin
                    scan_byte(CH_BSLASH);
                    scan_byte(c);
                    join_st = SP_IDLE;
                end
            end
            SP_BSL_CR:
            begin
                if (c == CH_LF)
                begin
                    scan_byte(CH_SPACE);
                    join_st = SP_IDLE;
                end
                else
                begin
                    scan_byte(CH_BSLASH);
                    scan_byte(CH_CR);
                    join_fresh(c);
                end
            end
            default:
                join_fresh(c);
        endcase
    endfunction

    // Work out the cleaned bytes owed for one accepted beat and queue them.
    function automatic void predict_cleaned(stim_t beat);
        out_n = 0;
        join_byte(beat.b);
        if (beat.last)
        begin
            // flush whatever lookahead is still held
            if (join_st == SP_BSL)
                scan_byte(CH_BSLASH);
            else if (join_st == SP_BSL_CR)
            begin
                scan_byte(CH_BSLASH);
                scan_byte(CH_CR);
            end
            join_st = SP_IDLE;
            if (slash_waiting && scan_mode == LX_CODE)
                put_clean(pending_byte);
        end
        if (beat.typed)
            clean_q.push_back('{b: beat.eb, last: beat.last});
        else
            for (int i = 0; i < out_n; i++)
                clean_q.push_back('{b: out_buf[i], last: beat.last && (i == out_n - 1)});
        if (beat.last)
            clear_stripper();
    endfunction

    // ------------------------------------------------------------------
    // Random text
    // ------------------------------------------------------------------
    function automatic byte_t pick_content();
        case ($urandom_range(0, 8))
            0:       return CH_STAR;
            1:       return CH_SLASH;
            2:       return CH_BSLASH;
            3:       return CH_DQUOTE;
            4:       return CH_SQUOTE;
            5:       return CH_LF;
            6:       return CH_CR;
            7:       return CH_SPACE;
            default: return byte_t'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    function automatic byte_t pick_letter();
        return byte_t'($urandom_range(8'h61, 8'h7A));
    endfunction

    // Append one lexical piece; mostly well-formed, sometimes cut short.
    function automatic void add_token();
        int n;
        n = 0;
        case ($urandom_range(0, 19))
            0, 1, 2, 3:
                repeat ($urandom_range(1, 4)) text_buf.push_back(pick_letter());
            4, 5:
                text_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_LF);
            6, 7:
            begin
                text_buf.push_back(CH_SLASH);
                text_buf.push_back(CH_SLASH);
                repeat ($urandom_range(0, 5)) text_buf.push_back(pick_content());
                if ($urandom_range(0, 4) != 0)
                    text_buf.push_back(CH_LF);
            end
            8, 9:
            begin
                text_buf.push_back(CH_SLASH);
                text_buf.push_back(CH_STAR);
                repeat ($urandom_range(0, 6)) text_buf.push_back(pick_content());
                if ($urandom_range(0, 4) != 0)
                begin
                    text_buf.push_back(CH_STAR);
                    text_buf.push_back(CH_SLASH);
                end
            end
            10, 11:
            begin
                text_buf.push_back(CH_DQUOTE);
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        // escape followed by any byte at all, NUL included
                        text_buf.push_back(CH_BSLASH);
                        text_buf.push_back(byte_t'($urandom_range(0, 255)));
                    end
                    else
                        text_buf.push_back(pick_content());
                end
                if ($urandom_range(0, 6) != 0)
                    text_buf.push_back(CH_DQUOTE);
            end
            12:
            begin
                text_buf.push_back(CH_SQUOTE);
                if ($urandom_range(0, 1) != 0)
                begin
                    text_buf.push_back(CH_BSLASH);
                    text_buf.push_back(byte_t'($urandom_range(0, 255)));
                end
                else
                    text_buf.push_back(pick_content());
                text_buf.push_back(CH_SQUOTE);
            end
            13, 14:
            begin
                text_buf.push_back(CH_BSLASH);
                case ($urandom_range(0, 4))
                    0:       text_buf.push_back(CH_LF);
                    1:
                    begin
                        text_buf.push_back(CH_CR);
                        text_buf.push_back(CH_LF);
                    end
                    2:
                    begin
                        text_buf.push_back(CH_CR);
                        text_buf.push_back(pick_content());
                    end
                    3:       text_buf.push_back(CH_BSLASH);
                    default: text_buf.push_back(pick_letter());
                endcase
            end
            15:
            begin
                text_buf.push_back(CH_SLASH);
                text_buf.push_back(pick_content());
            end
            16:
                text_buf.push_back(CH_STAR);
            default:
                text_buf.push_back(byte_t'($urandom_range(0, 255)));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    task automatic offer_beat(input stim_t beat);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        offered_q.push_back(beat);
        s_tdata  <= beat.b;
        s_tlast  <= beat.last;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver: stalls in stretches of differing character
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int span;
        int phase;
        m_tready = 1'b0;
        phase    = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 40);
            repeat (span)
            begin
                @(negedge clk);
                phase++;
                case (mode)
                    0:       m_tready <= 1'b1;                         // no stalls
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 4) == 0);  // heavy stall
                    default: m_tready <= (phase % 3 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check master beats, predict on slave beats
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        clean_t want;
        stim_t  beat;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (clean_q.size() == 0)
                report_mismatch($sformatf("unexpected beat data %02h last %b",
                                          m_tdata, m_tlast));
            else
            begin
                want = clean_q.pop_front();
                if (m_tdata !== want.b)
                    report_mismatch($sformatf("data %02h, wanted %02h", m_tdata, want.b));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %b, wanted %b (data %02h)",
                                              m_tlast, want.last, want.b));
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            beat = offered_q.pop_front();
            predict_cleaned(beat);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int    sent;
        int    target;
        bit    noise_only;
        stim_t beat;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        clear_stripper();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
            offer_beat(DIRECTED_ROWS[i]);

        // Random texts, each closed by a last-flagged byte. One in eight is
        // raw noise; the rest are built from mostly well-formed pieces.
        sent = 0;
        while (sent < N_RANDOM)
        begin
            text_buf.delete();
            noise_only = ($urandom_range(0, 7) == 0);
            target     = noise_only ? $urandom_range(1, 12) : $urandom_range(1, 40);
            while (text_buf.size() < target)
            begin
                if (noise_only)
                    text_buf.push_back(byte_t'($urandom_range(0, 255)));
                else
                    add_token();
            end
            foreach (text_buf[i])
            begin
                beat = '{b: text_buf[i], last: (i == text_buf.size() - 1),
                         typed: 1'b0, eb: 8'h00};
                offer_beat(beat);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        // drain, then keep watching for any stray beat to show up
        while (clean_q.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
